[src/mpq_pkg.sv]
package mpq_pkg;

  localparam int unsigned CAPACITY_DEF = 256;
  localparam int unsigned KEY_W        = 64;
  localparam int unsigned OPCODE_W     = 2;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned COUNT_W      = 9;

  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_PEEK   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OPCODE_W-1:0]    opcode;
    logic signed [KEY_W-1:0] key;
  } in_beat_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] value;
    logic [STATUS_W-1:0]     status;
    logic [COUNT_W-1:0]      count;
  } out_beat_t;

  // broadcast to every cell
  typedef struct packed {
    logic                    ins;
    logic                    del;
    logic signed [KEY_W-1:0] key;
  } mpq_ctl_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic                    valid;
    logic                    ge;
    logic signed [KEY_W-1:0] key;
  } mpq_link_t;

endpackage

[src/max_priority_queue.sv]
// Max priority queue of signed 64-bit keys, held as a row of CAPACITY cells
// kept in descending order (cell 0 holds the maximum). An insert shifts the
// smaller keys one cell down and drops the new key into the gap, a delete
// shifts all keys one cell up. busy never rises, so a command can be issued
// on every cycle, and its result appears on out_beat
// with out_valid high for exactly one cycle, the cycle after start. There is
// no way to stall the result; the receiver must take it then. Status reports
// an empty queue on delete or peek and a full queue on insert (key dropped).
module max_priority_queue
  import mpq_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  output out_beat_t out_beat
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  out_beat_t        out_beat_r, out_beat_nxt;
  mpq_ctl_t         ctl;
  mpq_link_t        link [CAPACITY];
  mpq_link_t        head_side;
  mpq_link_t        tail_side;
  logic             accept, full, empty;
  logic [CNT_W+COUNT_W-1:0] count_wide;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(CAPACITY));
  assign empty  = (count_r == '0);

  assign head_side.valid = 1'b1;
  assign head_side.ge    = 1'b1;
  assign head_side.key   = '0;
  assign tail_side       = '0;

  always_comb begin
    ctl.ins      = 1'b0;
    ctl.del      = 1'b0;
    ctl.key      = in_beat.key;
    count_nxt    = count_r;
    out_beat_nxt = '0;
    out_beat_nxt.status = ST_OK;
    if (accept) begin
      case (in_beat.opcode)
        OP_INSERT: begin
          if (full) begin
            out_beat_nxt.status = ST_FULL;
          end else begin
            ctl.ins   = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        OP_DELETE: begin
          if (empty) begin
            out_beat_nxt.status = ST_EMPTY;
          end else begin
            ctl.del            = 1'b1;
            count_nxt          = count_r - 1'b1;
            out_beat_nxt.value = link[0].key;
          end
        end
        OP_PEEK: begin
          if (empty) begin
            out_beat_nxt.status = ST_EMPTY;
          end else begin
            out_beat_nxt.value = link[0].key;
          end
        end
        default: begin
        end
      endcase
    end
    count_wide         = {{COUNT_W{1'b0}}, count_nxt};
    out_beat_nxt.count = count_wide[COUNT_W-1:0];
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    mpq_link_t prev_l, next_l;
    if (i == 0) begin : g_head
      assign prev_l = head_side;
    end else begin : g_prev
      assign prev_l = link[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_l = tail_side;
    end else begin : g_next
      assign next_l = link[i+1];
    end
    mpq_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl  (ctl),
      .prev (prev_l),
      .next (next_l),
      .self (link[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    out_beat_r <= out_beat_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

[src/mpq_cell.sv]
module mpq_cell
  import mpq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  mpq_ctl_t  ctl,
  input  mpq_link_t prev,
  input  mpq_link_t next,
  output mpq_link_t self
);

  logic                    valid_r, valid_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic                    ge;

  assign ge = valid_r && (key_r >= ctl.key);

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    if (ctl.ins) begin
      if (!ge) begin
        valid_nxt = valid_r | prev.valid;
        key_nxt   = prev.ge ? ctl.key : prev.key;
      end
    end else if (ctl.del) begin
      valid_nxt = next.valid;
      key_nxt   = next.key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign self.valid = valid_r;
  assign self.ge    = ge;
  assign self.key   = key_r;

endmodule
